@@ design/diag_session_reply_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// diag session reply scanner assertion macros
// clocked on clock, disabled during reset
// ----------------------------------------------------------------------------
`ifndef DIAG_SESSION_REPLY_SCANNER_MACROS_SVH
`define DIAG_SESSION_REPLY_SCANNER_MACROS_SVH

// consequent in the same cycle
`define DSRS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the following cycle
`define DSRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/dsrs_pkg.sv @@
// ----------------------------------------------------------------------------
// dsrs_pkg
// shared constants, codes and types of the diag session reply scanner
// ----------------------------------------------------------------------------
package dsrs_pkg;

   localparam int DSRS_IGNORE_DEPTH = 128;
   localparam int DSRS_FRAME_LIMIT  = 200;

   localparam int DSRS_ID_W    = 29;
   localparam int DSRS_BYTE_W  = 8;
   localparam int DSRS_TICK_W  = 24;
   localparam int DSRS_CNT8_W  = 8;
   localparam int DSRS_OP_W    = 2;
   localparam int DSRS_CODE_W  = 2;
   localparam int DSRS_WORD_W  = 32;
   localparam int DSRS_CSR_A_W = 2;

   localparam int DSRS_REQ_TDATA_W = 64;
   localparam int DSRS_REQ_TUSER_W = 2;
   localparam int DSRS_RSP_TDATA_W = 72;
   localparam int DSRS_RSP_TUSER_W = 4;

   // input operations
   localparam logic [DSRS_OP_W-1:0] OP_START = 2'd0;
   localparam logic [DSRS_OP_W-1:0] OP_FRAME = 2'd1;
   localparam logic [DSRS_OP_W-1:0] OP_TICK  = 2'd2;

   // end causes
   localparam logic [DSRS_CODE_W-1:0] CAUSE_SILENCE = 2'd0;
   localparam logic [DSRS_CODE_W-1:0] CAUSE_FULL    = 2'd1;
   localparam logic [DSRS_CODE_W-1:0] CAUSE_FRAMES  = 2'd2;

   // outcomes
   localparam logic [DSRS_CODE_W-1:0] OUTCOME_NONE   = 2'd0;
   localparam logic [DSRS_CODE_W-1:0] OUTCOME_SINGLE = 2'd1;
   localparam logic [DSRS_CODE_W-1:0] OUTCOME_MULTI  = 2'd2;

   // register indexes
   localparam logic [DSRS_CSR_A_W-1:0] CSR_ADDR_MODE = 2'd0;
   localparam logic [DSRS_CSR_A_W-1:0] CSR_SESSION   = 2'd1;
   localparam logic [DSRS_CSR_A_W-1:0] CSR_TARGET    = 2'd2;
   localparam logic [DSRS_CSR_A_W-1:0] CSR_SILENCE   = 2'd3;

   localparam logic [DSRS_BYTE_W-1:0] REPLY_SID     = 8'h50;
   localparam logic [DSRS_BYTE_W-1:0] SESSION_RESET = 8'h01;
   localparam logic [DSRS_TICK_W-1:0] SILENCE_RESET = 24'd10000;
   localparam logic [DSRS_TICK_W-1:0] TICK_MAX      = 24'hFF_FFFF;
   localparam logic [DSRS_CNT8_W-1:0] CNT8_MAX      = 8'hFF;

   typedef struct packed {
      logic done;
      logic found;
   } dsrs_search_sts_type;

endpackage

@@ design/diag_session_reply_scanner.sv @@
// ----------------------------------------------------------------------------
// diag_session_reply_scanner
// watches received frames and ticks after a session request and reports
// who answered when the scan ends
// ----------------------------------------------------------------------------
// channel  ports     dir  content
// req      req_t*    in   op in tuser, identifier and data bytes in tdata
// rsp      rsp_t*    out  end cause and outcome in tuser, result in tdata
// csr      csr_*     in   register writes, no read-back
//
// start, tick and unused ops pass the take and execute states; a frame adds a
// search on the single read port of the ignore list memory; a scan end adds the
// finish state; reset is synchronous; the ignore list is not cleared, its fill
// count bounds the search
// results wait in an output register; the next item is taken meanwhile and
// only an item that ends a scan waits for the register to drain
// ----------------------------------------------------------------------------
module diag_session_reply_scanner #(
   parameter int IGNORE_DEPTH = dsrs_pkg::DSRS_IGNORE_DEPTH,
   parameter int FRAME_LIMIT  = dsrs_pkg::DSRS_FRAME_LIMIT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // frame_id, byte0, byte1, byte2, byte3
   input  logic [dsrs_pkg::DSRS_REQ_TDATA_W-1:0]   req_tdata,
   // op
   input  logic [dsrs_pkg::DSRS_REQ_TUSER_W-1:0]   req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // responder_id, hit_count, result_word
   output logic [dsrs_pkg::DSRS_RSP_TDATA_W-1:0]   rsp_tdata,
   // end_cause, outcome
   output logic [dsrs_pkg::DSRS_RSP_TUSER_W-1:0]   rsp_tuser,
   input  logic                                    csr_we,
   input  logic [dsrs_pkg::DSRS_CSR_A_W-1:0]       csr_addr,
   input  logic [dsrs_pkg::DSRS_TICK_W-1:0]        csr_wdata
);
   import dsrs_pkg::*;

`include "diag_session_reply_scanner_macros.svh"

   localparam int ADDR_W = $clog2(IGNORE_DEPTH);
   localparam int CNT_W  = $clog2(IGNORE_DEPTH + 1);
   localparam logic [CNT_W-1:0]       DEPTH_CNT = CNT_W'(IGNORE_DEPTH);
   localparam logic [DSRS_CNT8_W-1:0] FRAME_LIM = DSRS_CNT8_W'(FRAME_LIMIT);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   // configuration
   logic                   mode_ff;
   logic [DSRS_BYTE_W-1:0] session_ff;
   logic [DSRS_BYTE_W-1:0] target_ff;
   logic [DSRS_TICK_W-1:0] limit_ff;

   // control and scan state
   logic [1:0]             state_ff, state_in;
   logic                   scanning_ff, scanning_in;
   logic [CNT_W-1:0]       ign_cnt_ff, ign_cnt_in;
   logic [DSRS_CNT8_W-1:0] hits_ff, hits_in;
   logic [DSRS_ID_W-1:0]   first_ff, first_in;
   logic [DSRS_TICK_W-1:0] ticks_ff, ticks_in;
   logic [DSRS_CNT8_W-1:0] frames_ff, frames_in;
   logic [DSRS_CODE_W-1:0] cause_ff, cause_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;

   // held item
   logic [DSRS_OP_W-1:0]   op_ff, op_in;
   logic [DSRS_ID_W-1:0]   id_ff, id_in;
   logic [DSRS_BYTE_W-1:0] b0_ff, b0_in;
   logic [DSRS_BYTE_W-1:0] b1_ff, b1_in;
   logic [DSRS_BYTE_W-1:0] b2_ff, b2_in;
   logic [DSRS_BYTE_W-1:0] b3_ff, b3_in;

   // result register
   logic [DSRS_CODE_W-1:0] res_cause_ff;
   logic [DSRS_CODE_W-1:0] res_outcome_ff, res_outcome_in;
   logic [DSRS_ID_W-1:0]   res_resp_ff, res_resp_in;
   logic [DSRS_CNT8_W-1:0] res_hits_ff, res_hits_in;
   logic [DSRS_WORD_W-1:0] res_word_ff, res_word_in;

   logic                   positive;
   logic [DSRS_TICK_W-1:0] tick_inc;
   logic [DSRS_CNT8_W-1:0] hits_inc;
   logic [DSRS_CNT8_W-1:0] frames_inc;
   logic [CNT_W-1:0]       cnt_inc;
   logic                   srch_start;
   logic                   ign_wr_en;
   logic                   rsp_load;
   dsrs_search_sts_type    srch_sts;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, res_word_ff, res_hits_ff, res_resp_ff};
   assign rsp_tuser  = {res_outcome_ff, res_cause_ff};

   assign positive = mode_ff ? ((b0_ff == target_ff) && (b2_ff == REPLY_SID) &&
                                (b3_ff == session_ff))
                             : ((b1_ff == REPLY_SID) && (b2_ff == session_ff));
   assign tick_inc   = (ticks_ff != TICK_MAX) ? ticks_ff + DSRS_TICK_W'(1) : ticks_ff;
   assign hits_inc   = (hits_ff != CNT8_MAX) ? hits_ff + DSRS_CNT8_W'(1) : hits_ff;
   assign frames_inc = (frames_ff != CNT8_MAX) ? frames_ff + DSRS_CNT8_W'(1) : frames_ff;
   assign cnt_inc    = ign_cnt_ff + CNT_W'(1);

   // result fields from the hit count
   always_comb begin
      if (hits_ff == '0) begin
         res_outcome_in = OUTCOME_NONE;
         res_resp_in    = '0;
         res_hits_in    = '0;
         res_word_in    = '0;
      end else if (hits_ff == DSRS_CNT8_W'(1)) begin
         res_outcome_in = OUTCOME_SINGLE;
         res_resp_in    = first_ff;
         res_hits_in    = hits_ff;
         res_word_in    = {3'b100, first_ff};
      end else begin
         res_outcome_in = OUTCOME_MULTI;
         res_resp_in    = first_ff;
         res_hits_in    = hits_ff;
         res_word_in    = {2'b11, 22'd0, hits_ff};
      end
   end

   always_comb begin
      state_in    = state_ff;
      scanning_in = scanning_ff;
      ign_cnt_in  = ign_cnt_ff;
      hits_in     = hits_ff;
      first_in    = first_ff;
      ticks_in    = ticks_ff;
      frames_in   = frames_ff;
      cause_in    = cause_ff;
      op_in       = op_ff;
      id_in       = id_ff;
      b0_in       = b0_ff;
      b1_in       = b1_ff;
      b2_in       = b2_ff;
      b3_in       = b3_ff;
      srch_start  = 1'b0;
      ign_wr_en   = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[1:0];
               id_in    = req_tdata[28:0];
               b0_in    = req_tdata[36:29];
               b1_in    = req_tdata[44:37];
               b2_in    = req_tdata[52:45];
               b3_in    = req_tdata[60:53];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (op_ff)
               OP_START: begin
                  scanning_in = 1'b1;
                  ign_cnt_in  = '0;
                  hits_in     = '0;
                  first_in    = '0;
                  ticks_in    = '0;
                  frames_in   = '0;
               end
               OP_TICK: begin
                  if (scanning_ff) begin
                     ticks_in = tick_inc;
                     if (tick_inc >= limit_ff) begin
                        cause_in = CAUSE_SILENCE;
                        state_in = S_FINISH;
                     end
                  end
               end
               OP_FRAME: begin
                  if (scanning_ff) begin
                     srch_start = 1'b1;
                     state_in   = S_SEARCH;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SEARCH: begin
            if (srch_sts.done) begin
               frames_in = frames_inc;
               state_in  = S_IDLE;
               if (!srch_sts.found) begin
                  ticks_in = '0;
                  if (positive) begin
                     if (hits_ff == '0) begin
                        first_in = id_ff;
                     end
                     hits_in = hits_inc;
                  end else begin
                     ign_wr_en  = 1'b1;
                     ign_cnt_in = cnt_inc;
                  end
               end
               if (!srch_sts.found && !positive && (cnt_inc == DEPTH_CNT)) begin
                  cause_in = CAUSE_FULL;
                  state_in = S_FINISH;
               end else if (frames_inc >= FRAME_LIM) begin
                  cause_in = CAUSE_FRAMES;
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load    = 1'b1;
               scanning_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid_in = rsp_load || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scanning_ff   <= 1'b0;
         ign_cnt_ff    <= '0;
         hits_ff       <= '0;
         first_ff      <= '0;
         ticks_ff      <= '0;
         frames_ff     <= '0;
         cause_ff      <= CAUSE_SILENCE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scanning_ff   <= scanning_in;
         ign_cnt_ff    <= ign_cnt_in;
         hits_ff       <= hits_in;
         first_ff      <= first_in;
         ticks_ff      <= ticks_in;
         frames_ff     <= frames_in;
         cause_ff      <= cause_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      id_ff <= id_in;
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      b3_ff <= b3_in;
      if (rsp_load) begin
         res_cause_ff   <= cause_ff;
         res_outcome_ff <= res_outcome_in;
         res_resp_ff    <= res_resp_in;
         res_hits_ff    <= res_hits_in;
         res_word_ff    <= res_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         session_ff <= SESSION_RESET;
         target_ff  <= '0;
         limit_ff   <= SILENCE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ADDR_MODE: mode_ff    <= csr_wdata[0];
            CSR_SESSION:   session_ff <= csr_wdata[7:0];
            CSR_TARGET:    target_ff  <= csr_wdata[7:0];
            CSR_SILENCE:   limit_ff   <= csr_wdata;
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   dsrs_ignore_list #(
      .IGNORE_DEPTH (IGNORE_DEPTH)
   ) u_ignore_list (
      .clock      (clock),
      .reset      (reset),
      .srch_start (srch_start),
      .srch_key   (id_ff),
      .srch_fill  (ign_cnt_ff),
      .wr_en      (ign_wr_en),
      .wr_addr    (ign_cnt_ff[ADDR_W-1:0]),
      .wr_data    (id_ff),
      .srch_sts   (srch_sts)
   );

   `DSRS_ASSERT_SAME(a_done_in_search, srch_sts.done, state_ff == S_SEARCH,
                     "search completion outside the search state")
   `DSRS_ASSERT_SAME(a_wr_below_depth, ign_wr_en, ign_cnt_ff < DEPTH_CNT,
                     "ignore list write beyond its depth")
   `DSRS_ASSERT_SAME(a_idle_not_full, scanning_ff && (state_ff == S_IDLE),
                     ign_cnt_ff < DEPTH_CNT, "scan still open with a full ignore list")
   `DSRS_ASSERT_NEXT(a_finish_closes, rsp_load, rsp_tvalid_ff && !scanning_ff,
                     "scan end did not present a result and close the scan")

endmodule

@@ design/dsrs_ignore_list.sv @@
// ----------------------------------------------------------------------------
// dsrs_ignore_list
// ignore list memory with a linear search, one entry read per cycle
// ----------------------------------------------------------------------------
module dsrs_ignore_list #(
   parameter int IGNORE_DEPTH = dsrs_pkg::DSRS_IGNORE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                srch_start,
   input  logic [dsrs_pkg::DSRS_ID_W-1:0]      srch_key,
   input  logic [$clog2(IGNORE_DEPTH+1)-1:0]   srch_fill,
   input  logic                                wr_en,
   input  logic [$clog2(IGNORE_DEPTH)-1:0]     wr_addr,
   input  logic [dsrs_pkg::DSRS_ID_W-1:0]      wr_data,
   output dsrs_pkg::dsrs_search_sts_type       srch_sts
);
   import dsrs_pkg::*;

   localparam int ADDR_W = $clog2(IGNORE_DEPTH);
   localparam int CNT_W  = $clog2(IGNORE_DEPTH + 1);

   logic [DSRS_ID_W-1:0] mem [IGNORE_DEPTH];

   logic                 busy_ff, busy_in;
   logic                 pend_ff, pend_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [DSRS_ID_W-1:0] key_ff, key_in;
   logic [DSRS_ID_W-1:0] rd_data_ff;
   logic                 rd_en;
   logic                 hit;

   assign hit = pend_ff && (rd_data_ff == key_ff);

   always_comb begin
      busy_in         = busy_ff;
      pend_in         = pend_ff;
      issue_in        = issue_ff;
      fill_in         = fill_ff;
      key_in          = key_ff;
      rd_en           = 1'b0;
      srch_sts.done   = 1'b0;
      srch_sts.found  = 1'b0;
      if (srch_start) begin
         busy_in  = 1'b1;
         pend_in  = 1'b0;
         issue_in = '0;
         fill_in  = srch_fill;
         key_in   = srch_key;
      end else if (busy_ff) begin
         if (hit) begin
            srch_sts.done  = 1'b1;
            srch_sts.found = 1'b1;
            busy_in        = 1'b0;
            pend_in        = 1'b0;
         end else if (issue_ff < fill_ff) begin
            rd_en    = 1'b1;
            issue_in = issue_ff + CNT_W'(1);
            pend_in  = 1'b1;
         end else begin
            srch_sts.done = 1'b1;
            busy_in       = 1'b0;
            pend_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
      end
      issue_ff <= issue_in;
      fill_ff  <= fill_in;
      key_ff   <= key_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[ADDR_W-1:0]];
      end
   end

endmodule
